>>> design/cpfc_pkg.sv
`timescale 1ns / 1ps

package cpfc_pkg;

   typedef enum logic [1:0] {
      MODE_YUV_RGB  = 2'd0,
      MODE_YUV_YUV  = 2'd1,
      MODE_RGBA_RGB = 2'd2,
      MODE_BGRA_RGB = 2'd3
   } mode_type;

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam logic CSR_MODE_INDEX = 1'b0;

   localparam int CHROMA_OFFSET = 128;

   typedef struct packed {
      logic [7:0] byte_zero;
      logic [7:0] byte_one;
      logic [7:0] byte_two;
      logic [7:0] byte_three;
      logic       final_word;
   } word_type;

   typedef struct packed {
      logic [7:0] chan_a;
      logic [7:0] chan_b;
      logic [7:0] chan_c;
   } pixel_type;

   typedef struct packed {
      pixel_type pix0;
      pixel_type pix1;
      logic      two_pix;
      logic      fin;
   } pair_type;

   // round half up of milli/1000 scaled by 2^frac
   function automatic int coef_q(input int milli, input int frac);
      return ((milli << frac) + 500) / 1000;
   endfunction

endpackage

>>> design/cpfc_channels.sv
`timescale 1ns / 1ps

interface cpfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_zero;
   logic [7:0] byte_one;
   logic [7:0] byte_two;
   logic [7:0] byte_three;
   logic       final_word;

   modport source (output valid, byte_zero, byte_one, byte_two, byte_three, final_word,
                   input ready);
   modport sink (input valid, byte_zero, byte_one, byte_two, byte_three, final_word,
                 output ready);
endinterface

interface cpfc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] channel_a;
   logic [7:0] channel_b;
   logic [7:0] channel_c;
   logic       frame_end;

   modport source (output valid, channel_a, channel_b, channel_c, frame_end,
                   input ready);
   modport sink (input valid, channel_a, channel_b, channel_c, frame_end,
                 output ready);
endinterface

>>> design/cpfc_csr.sv
`timescale 1ns / 1ps

module cpfc_csr
   import cpfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output mode_type              mode
);

   mode_type mode_ff;
   logic     hit_mode;

   assign hit_mode = (paddr[2] == CSR_MODE_INDEX);
   assign pready   = 1'b1;
   assign mode     = mode_ff;

   always_comb begin
      prdata = '0;
      if (hit_mode) begin
         prdata = {{(CSR_DATA_W-2){1'b0}}, mode_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_YUV_RGB;
      end else if (psel && penable && pwrite && hit_mode) begin
         mode_ff <= mode_type'(pwdata[1:0]);
      end
   end

endmodule

>>> design/cpfc_mult.sv
`timescale 1ns / 1ps

module cpfc_mult
   import cpfc_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 10,
   parameter int PROD_W         = COEF_FRAC_BITS + 13
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  word_type                 in_word,
   input  mode_type                 in_mode,
   output logic                     out_valid,
   input  logic                     out_ready,
   output word_type                 out_word,
   output mode_type                 out_mode,
   output logic signed [PROD_W-1:0] out_rv,
   output logic signed [PROD_W-1:0] out_gu,
   output logic signed [PROD_W-1:0] out_gv,
   output logic signed [PROD_W-1:0] out_bu
);

   localparam int COEF_W = COEF_FRAC_BITS + 2;
   localparam logic [COEF_W-1:0] COEF_RV = COEF_W'(coef_q(1140, COEF_FRAC_BITS));
   localparam logic [COEF_W-1:0] COEF_GU = COEF_W'(coef_q(396, COEF_FRAC_BITS));
   localparam logic [COEF_W-1:0] COEF_GV = COEF_W'(coef_q(581, COEF_FRAC_BITS));
   localparam logic [COEF_W-1:0] COEF_BU = COEF_W'(coef_q(2029, COEF_FRAC_BITS));

   logic     a_v_ff;
   word_type a_word_ff;
   mode_type a_mode_ff;
   logic     b_v_ff;
   word_type b_word_ff;
   mode_type b_mode_ff;
   logic signed [PROD_W-1:0] b_rv_ff, b_gu_ff, b_gv_ff, b_bu_ff;

   logic a_ready, b_ready;
   logic signed [9:0] chroma_d, chroma_e;
   logic signed [PROD_W-1:0] d_ext, e_ext;

   assign b_ready  = !b_v_ff || out_ready;
   assign a_ready  = !a_v_ff || b_ready;
   assign in_ready = a_ready;

   assign chroma_d = $signed({2'b00, a_word_ff.byte_one}) - 10'(CHROMA_OFFSET);
   assign chroma_e = $signed({2'b00, a_word_ff.byte_three}) - 10'(CHROMA_OFFSET);
   assign d_ext    = PROD_W'(chroma_d);
   assign e_ext    = PROD_W'(chroma_e);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_v_ff <= in_valid;
         end
         if (b_ready) begin
            b_v_ff <= a_v_ff;
         end
      end
      if (a_ready && in_valid) begin
         a_word_ff <= in_word;
         a_mode_ff <= in_mode;
      end
      if (b_ready && a_v_ff) begin
         b_word_ff <= a_word_ff;
         b_mode_ff <= a_mode_ff;
         b_rv_ff   <= $signed(PROD_W'(COEF_RV)) * e_ext;
         b_gu_ff   <= $signed(PROD_W'(COEF_GU)) * d_ext;
         b_gv_ff   <= $signed(PROD_W'(COEF_GV)) * e_ext;
         b_bu_ff   <= $signed(PROD_W'(COEF_BU)) * d_ext;
      end
   end

   assign out_valid = b_v_ff;
   assign out_word  = b_word_ff;
   assign out_mode  = b_mode_ff;
   assign out_rv    = b_rv_ff;
   assign out_gu    = b_gu_ff;
   assign out_gv    = b_gv_ff;
   assign out_bu    = b_bu_ff;

endmodule

>>> design/cpfc_mix.sv
`timescale 1ns / 1ps

module cpfc_mix
   import cpfc_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 10,
   parameter int PROD_W         = COEF_FRAC_BITS + 13
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  word_type                 in_word,
   input  mode_type                 in_mode,
   input  logic signed [PROD_W-1:0] in_rv,
   input  logic signed [PROD_W-1:0] in_gu,
   input  logic signed [PROD_W-1:0] in_gv,
   input  logic signed [PROD_W-1:0] in_bu,
   output logic                     out_valid,
   input  logic                     out_ready,
   output pair_type                 out_pair
);

   localparam int SUM_W = COEF_FRAC_BITS + 15;

   logic     c_v_ff;
   word_type c_word_ff;
   mode_type c_mode_ff;
   logic signed [SUM_W-1:0] c_r0_ff, c_g0_ff, c_b0_ff, c_r1_ff, c_g1_ff, c_b1_ff;
   logic     d_v_ff;
   pair_type d_pair_ff;

   logic c_ready, d_ready;
   logic signed [SUM_W-1:0] base0, base1, rv_ext, gu_ext, gv_ext, bu_ext;
   pair_type pair_in;

   function automatic logic [7:0] clamp_px(input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W-1:0] s;
      s = x >>> COEF_FRAC_BITS;
      if (s[SUM_W-1]) begin
         return 8'd0;
      end else if (|s[SUM_W-2:8]) begin
         return 8'd255;
      end
      return s[7:0];
   endfunction

   assign d_ready  = !d_v_ff || out_ready;
   assign c_ready  = !c_v_ff || d_ready;
   assign in_ready = c_ready;

   assign base0  = SUM_W'($signed({1'b0, in_word.byte_zero, {COEF_FRAC_BITS{1'b0}}}));
   assign base1  = SUM_W'($signed({1'b0, in_word.byte_two, {COEF_FRAC_BITS{1'b0}}}));
   assign rv_ext = SUM_W'(in_rv);
   assign gu_ext = SUM_W'(in_gu);
   assign gv_ext = SUM_W'(in_gv);
   assign bu_ext = SUM_W'(in_bu);

   always_comb begin
      pair_in.fin     = c_word_ff.final_word;
      pair_in.two_pix = 1'b1;
      pair_in.pix0    = '{c_word_ff.byte_zero, c_word_ff.byte_one, c_word_ff.byte_two};
      pair_in.pix1    = pair_in.pix0;
      case (c_mode_ff)
         MODE_YUV_RGB: begin
            pair_in.pix0 = '{clamp_px(c_r0_ff), clamp_px(c_g0_ff), clamp_px(c_b0_ff)};
            pair_in.pix1 = '{clamp_px(c_r1_ff), clamp_px(c_g1_ff), clamp_px(c_b1_ff)};
         end
         MODE_YUV_YUV: begin
            pair_in.pix0 = '{c_word_ff.byte_zero, c_word_ff.byte_one, c_word_ff.byte_three};
            pair_in.pix1 = '{c_word_ff.byte_two, c_word_ff.byte_one, c_word_ff.byte_three};
         end
         MODE_RGBA_RGB: begin
            pair_in.two_pix = 1'b0;
         end
         MODE_BGRA_RGB: begin
            pair_in.two_pix = 1'b0;
            pair_in.pix0    = '{c_word_ff.byte_two, c_word_ff.byte_one, c_word_ff.byte_zero};
         end
         default: begin
            pair_in.two_pix = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else begin
         if (c_ready) begin
            c_v_ff <= in_valid;
         end
         if (d_ready) begin
            d_v_ff <= c_v_ff;
         end
      end
      if (c_ready && in_valid) begin
         c_word_ff <= in_word;
         c_mode_ff <= in_mode;
         c_r0_ff   <= base0 + rv_ext;
         c_g0_ff   <= base0 - gu_ext - gv_ext;
         c_b0_ff   <= base0 + bu_ext;
         c_r1_ff   <= base1 + rv_ext;
         c_g1_ff   <= base1 - gu_ext - gv_ext;
         c_b1_ff   <= base1 + bu_ext;
      end
      if (d_ready && c_v_ff) begin
         d_pair_ff <= pair_in;
      end
   end

   assign out_valid = d_v_ff;
   assign out_pair  = d_pair_ff;

endmodule

>>> design/cpfc_serial.sv
`timescale 1ns / 1ps

module cpfc_serial
   import cpfc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  pair_type  in_pair,
   output logic      out_valid,
   input  logic      out_ready,
   output pixel_type out_pixel,
   output logic      out_end
);

   logic     v_ff;
   logic     phase_ff;
   pair_type pair_ff;
   logic     last_pix;
   logic     take;

   assign last_pix = !pair_ff.two_pix || phase_ff;
   assign take     = v_ff && out_ready;
   assign in_ready = !v_ff || (out_ready && last_pix);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= 1'b0;
         phase_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         v_ff     <= 1'b1;
         phase_ff <= 1'b0;
      end else if (take && last_pix) begin
         v_ff     <= 1'b0;
         phase_ff <= 1'b0;
      end else if (take) begin
         phase_ff <= 1'b1;
      end
      if (in_valid && in_ready) begin
         pair_ff <= in_pair;
      end
   end

   assign out_valid = v_ff;
   assign out_pixel = phase_ff ? pair_ff.pix1 : pair_ff.pix0;
   assign out_end   = pair_ff.fin && last_pix;

endmodule

>>> design/camera_pixel_format_converter.sv
`timescale 1ns / 1ps

// channel   dir   handshake        payload
// req_bus   in    valid / ready    byte_zero..byte_three, final_word
// rsp_bus   out   valid / ready    channel_a..channel_c, frame_end
// csr_*     in    apb write/read   conversion_mode at byte address 0
//
// five register stages: capture, chroma multiply, sum, shift/clamp/select, output word
// yuv modes give two pixels per source word, so the output register holds each word
// until its second pixel is taken; rgba/bgra modes take one word per cycle when rsp_bus
// is ready; a stall on rsp_bus backs up through every stage, nothing is dropped
// synchronous reset clears all valid bits and sets the mode to yuv422 to rgb

module camera_pixel_format_converter
   import cpfc_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 10
)
(
   input  logic                  clock,
   input  logic                  reset,
   cpfc_req_if.sink              req_bus,
   cpfc_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int PROD_W = COEF_FRAC_BITS + 13;

   mode_type  mode;
   word_type  req_word;
   logic      m_valid, m_ready;
   word_type  m_word;
   mode_type  m_mode;
   logic signed [PROD_W-1:0] m_rv, m_gu, m_gv, m_bu;
   logic      x_valid, x_ready;
   pair_type  x_pair;
   pixel_type rsp_pixel;

   assign req_word = '{req_bus.byte_zero, req_bus.byte_one, req_bus.byte_two,
                       req_bus.byte_three, req_bus.final_word};

   cpfc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .mode    (mode)
   );

   cpfc_mult #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .PROD_W         (PROD_W)
   ) u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_word   (req_word),
      .in_mode   (mode),
      .out_valid (m_valid),
      .out_ready (m_ready),
      .out_word  (m_word),
      .out_mode  (m_mode),
      .out_rv    (m_rv),
      .out_gu    (m_gu),
      .out_gv    (m_gv),
      .out_bu    (m_bu)
   );

   cpfc_mix #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .PROD_W         (PROD_W)
   ) u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid),
      .in_ready  (m_ready),
      .in_word   (m_word),
      .in_mode   (m_mode),
      .in_rv     (m_rv),
      .in_gu     (m_gu),
      .in_gv     (m_gv),
      .in_bu     (m_bu),
      .out_valid (x_valid),
      .out_ready (x_ready),
      .out_pair  (x_pair)
   );

   cpfc_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (x_valid),
      .in_ready  (x_ready),
      .in_pair   (x_pair),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_pixel (rsp_pixel),
      .out_end   (rsp_bus.frame_end)
   );

   assign rsp_bus.channel_a = rsp_pixel.chan_a;
   assign rsp_bus.channel_b = rsp_pixel.chan_b;
   assign rsp_bus.channel_c = rsp_pixel.chan_c;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench
   import cpfc_pkg::*;
();

   localparam int COEF_FRAC = 10;
   localparam int COEF_RV = ((1140 << COEF_FRAC) + 500) / 1000;
   localparam int COEF_GU = ((396 << COEF_FRAC) + 500) / 1000;
   localparam int COEF_GV = ((581 << COEF_FRAC) + 500) / 1000;
   localparam int COEF_BU = ((2029 << COEF_FRAC) + 500) / 1000;
   localparam logic [CSR_ADDR_W-1:0] MODE_ADDR = CSR_ADDR_W'(4 * CSR_MODE_INDEX);
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] chan_a;
      logic [7:0] chan_b;
      logic [7:0] chan_c;
      logic       frame_end;
   } out_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cpfc_req_if req_bus();
   cpfc_rsp_if rsp_bus();

   mode_type      active_mode = MODE_YUV_RGB;
   out_pixel_type pending_pixels[$];
   int            fail_count = 0;
   int            idle_cycles = 0;
   int            rsp_hold_cycles = 0;
   bit            sender_idle_en = 1'b1;
   bit            receiver_idle_en = 1'b1;

   camera_pixel_format_converter #(
      .COEF_FRAC_BITS(COEF_FRAC)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [7:0] clamp_byte(input int v);
      if (v > 255) begin
         return 8'd255;
      end
      if (v < 0) begin
         return 8'd0;
      end
      return v[7:0];
   endfunction

   function automatic out_pixel_type yuv_pixel(input logic [7:0] luma, input int d,
                                               input int e, input logic fe);
      int            base;
      out_pixel_type p;
      base = int'(luma) * (1 << COEF_FRAC);
      p.chan_a = clamp_byte((base + COEF_RV * e) >>> COEF_FRAC);
      p.chan_b = clamp_byte((base - COEF_GU * d - COEF_GV * e) >>> COEF_FRAC);
      p.chan_c = clamp_byte((base + COEF_BU * d) >>> COEF_FRAC);
      p.frame_end = fe;
      return p;
   endfunction

   function automatic void predict_pixels(input word_type w);
      int d;
      int e;
      d = int'(w.byte_one) - CHROMA_OFFSET;
      e = int'(w.byte_three) - CHROMA_OFFSET;
      case (active_mode)
         MODE_YUV_RGB: begin
            pending_pixels.push_back(yuv_pixel(w.byte_zero, d, e, 1'b0));
            pending_pixels.push_back(yuv_pixel(w.byte_two, d, e, w.final_word));
         end
         MODE_YUV_YUV: begin
            pending_pixels.push_back({w.byte_zero, w.byte_one, w.byte_three, 1'b0});
            pending_pixels.push_back({w.byte_two, w.byte_one, w.byte_three, w.final_word});
         end
         MODE_RGBA_RGB: begin
            pending_pixels.push_back({w.byte_zero, w.byte_one, w.byte_two, w.final_word});
         end
         default: begin
            pending_pixels.push_back({w.byte_two, w.byte_one, w.byte_zero, w.final_word});
         end
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      logic [7:0] corners[7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
      if ($urandom_range(0, 3) == 0) begin
         return corners[$urandom_range(0, 6)];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_word(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                            input logic [7:0] b3, input logic fin);
      int       gap;
      word_type w;
      gap = sender_idle_en ? $urandom_range(0, 6) : 0;
      w = {b0, b1, b2, b3, fin};
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.byte_zero  <= b0;
      req_bus.byte_one   <= b1;
      req_bus.byte_two   <= b2;
      req_bus.byte_three <= b3;
      req_bus.final_word <= fin;
      req_bus.valid      <= 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_pixels(w);
   endtask

   task automatic send_random_word();
      send_word(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                $urandom_range(0, 7) == 0);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   task automatic write_conversion_mode(input mode_type m);
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MODE_ADDR;
      csr_pwdata  <= CSR_DATA_W'(m);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      active_mode = m;
   endtask

   task automatic test_directed_yuv_rgb();
      // mode left at its reset value
      send_word(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      send_word(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_word(8'd0, 8'd128, 8'd255, 8'd128, 1'b0);
      send_word(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
      send_word(8'd128, 8'd255, 8'd16, 8'd0, 1'b1);
      send_word(8'd16, 8'd128, 8'd235, 8'd128, 1'b0);
      send_word(8'd76, 8'd85, 8'd29, 8'd255, 1'b0);
      send_word(8'd0, 8'd255, 8'd255, 8'd0, 1'b1);
   endtask

   task automatic test_directed_byte_modes();
      write_conversion_mode(MODE_YUV_YUV);
      send_word(8'd1, 8'd2, 8'd3, 8'd4, 1'b0);
      send_word(8'd255, 8'd0, 8'd255, 8'd0, 1'b1);
      send_word(8'd0, 8'd255, 8'd0, 8'd255, 1'b0);
      write_conversion_mode(MODE_RGBA_RGB);
      send_word(8'd10, 8'd20, 8'd30, 8'd0, 1'b0);
      send_word(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_word(8'd0, 8'd0, 8'd0, 8'hAA, 1'b0);
      write_conversion_mode(MODE_BGRA_RGB);
      send_word(8'd10, 8'd20, 8'd30, 8'd255, 1'b1);
      send_word(8'd255, 8'd0, 8'd128, 8'd0, 1'b0);
      send_word(8'd0, 8'd255, 8'd0, 8'h55, 1'b1);
   endtask

   task automatic test_random_modes();
      mode_type plan[8];
      plan = '{MODE_BGRA_RGB, MODE_YUV_RGB, MODE_YUV_YUV, MODE_RGBA_RGB,
               MODE_YUV_RGB, MODE_YUV_RGB, MODE_YUV_RGB, MODE_YUV_RGB};
      for (int i = 4; i < 8; i++) begin
         plan[i] = mode_type'($urandom_range(0, 3));
      end
      foreach (plan[i]) begin
         write_conversion_mode(plan[i]);
         repeat (140) send_random_word();
      end
   endtask

   task automatic test_no_idle();
      write_conversion_mode(mode_type'($urandom_range(0, 3)));
      sender_idle_en = 1'b0;
      receiver_idle_en = 1'b0;
      repeat (80) send_random_word();
      drain_results();
      sender_idle_en = 1'b1;
      receiver_idle_en = 1'b1;
   endtask

   task automatic test_output_backpressure();
      write_conversion_mode(MODE_YUV_RGB);
      sender_idle_en = 1'b0;
      rsp_hold_cycles = 120;
      repeat (60) send_random_word();
      sender_idle_en = 1'b1;
   endtask

   task automatic test_sender_pause();
      write_conversion_mode(mode_type'($urandom_range(0, 3)));
      repeat (40) send_random_word();
      drain_results();
      repeat (40) send_random_word();
   endtask

   // result side: random stalls, plus a long hold when one is requested
   initial begin : rsp_driver
      int stall;
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = receiver_idle_en ? $urandom_range(0, 6) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
      end
   end

   always @(posedge clock) begin
      out_pixel_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected output word: %h %h %h %b", rsp_bus.channel_a,
                   rsp_bus.channel_b, rsp_bus.channel_c, rsp_bus.frame_end);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_bus.channel_a !== want.chan_a) begin
               $error("channel_a: expected %0d, got %0d", want.chan_a, rsp_bus.channel_a);
               fail_count++;
            end
            if (rsp_bus.channel_b !== want.chan_b) begin
               $error("channel_b: expected %0d, got %0d", want.chan_b, rsp_bus.channel_b);
               fail_count++;
            end
            if (rsp_bus.channel_c !== want.chan_c) begin
               $error("channel_c: expected %0d, got %0d", want.chan_c, rsp_bus.channel_c);
               fail_count++;
            end
            if (rsp_bus.frame_end !== want.frame_end) begin
               $error("frame_end: expected %0d, got %0d", want.frame_end, rsp_bus.frame_end);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.byte_zero  <= 8'd0;
      req_bus.byte_one   <= 8'd0;
      req_bus.byte_two   <= 8'd0;
      req_bus.byte_three <= 8'd0;
      req_bus.final_word <= 1'b0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_yuv_rgb();
      test_directed_byte_modes();
      test_random_modes();
      test_no_idle();
      test_output_backpressure();
      test_sender_pause();

      drain_results();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

>>> camera_pixel_format_converter.f
design/cpfc_pkg.sv
design/cpfc_channels.sv
design/cpfc_csr.sv
design/cpfc_mult.sv
design/cpfc_mix.sv
design/cpfc_serial.sv
design/camera_pixel_format_converter.sv
tb/sv/testbench.sv
